/* rtl/core/hfil_pkg.sv */
// shared types, constants and hash function for the hashed first-index lookup core
package hfil_pkg;

   localparam int TABLE_SLOTS   = 1024;
   localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
   localparam int POSITION_BITS = 16;
   localparam int KEY_BITS      = 32;
   localparam int EPOCH_BITS    = 6;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEY_BITS-1:0]      HASH_MULT = 32'd2654435761;
   localparam logic [POSITION_BITS-1:0] COUNT_MAX = {POSITION_BITS{1'b1}};

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_INSERT,
      KIND_LOOKUP,
      KIND_IDLE
   } kind_type;

   typedef struct packed {
      logic [1:0]                 command;
      logic signed [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic                     found;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      kind_type               kind;
      logic                   key_zero;
      logic [KEY_BITS-1:0]    key;
      logic [SLOT_BITS-1:0]   home;
   } job_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0]    epoch;
      logic [KEY_BITS-1:0]      key;
      logic [POSITION_BITS-1:0] position;
   } entry_type;

   // only the low slot bits of key * mult survive the mask, so a narrow multiply suffices
   function automatic logic [SLOT_BITS-1:0] home_slot(input logic [KEY_BITS-1:0] key);
      logic [SLOT_BITS-1:0] key_lo;
      logic [SLOT_BITS-1:0] mult_lo;
      key_lo  = key[SLOT_BITS-1:0];
      mult_lo = HASH_MULT[SLOT_BITS-1:0];
      return SLOT_BITS'(key_lo * mult_lo);
   endfunction

endpackage

/* rtl/core/hashed_first_index_lookup_core.sv */
// top level of the hashed first-index lookup core
//
//   channel   ports                          beat contents
//   request   req_valid / req_ready / req    command, key
//   response  rsp_valid / rsp_ready / rsp    position, found, status
//
// one response beat per request beat, in order
// back end: a non-wrapping clear, zero key, saturated insert or unused command is answered from the idle state;
//   a nonzero key probes from its home slot (one slot memory read per cycle)
// front register and job queue keep taking beats while the back end probes or the
//   response register waits, as long as they have room
// after reset a sweep over all 1024 slots tags every slot empty; req_ready stays low meanwhile
// a clear that wraps the 6-bit generation tag runs the same sweep over all slots
module hashed_first_index_lookup_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hfil_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hfil_pkg::rsp_type rsp
);

   logic              init_done;
   logic              front_valid;
   logic              front_ready;
   hfil_pkg::job_type front_job;
   logic              queue_valid;
   logic              queue_ready;
   hfil_pkg::job_type queue_job;

   hfil_front u_front (
      .clock     (clock),
      .reset     (reset),
      .init_done (init_done),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job       (front_job)
   );

   hfil_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_job   (queue_job)
   );

   hfil_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job_ready (queue_ready),
      .job       (queue_job),
      .init_done (init_done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

/* rtl/core/hfil_front.sv */
// front stage: takes request beats, classifies them and computes the home slot
module hfil_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             init_done,
   input  logic             req_valid,
   output logic             req_ready,
   input  hfil_pkg::req_type req,
   output logic             job_valid,
   input  logic             job_ready,
   output hfil_pkg::job_type job
);

   logic              job_valid_ff;
   logic              job_valid_in;
   hfil_pkg::job_type job_ff;
   hfil_pkg::job_type job_in;
   hfil_pkg::kind_type kind;

   assign req_ready = init_done && (!job_valid_ff || job_ready);
   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   always_comb begin
      unique case (req.command)
         hfil_pkg::CMD_CLEAR:  kind = hfil_pkg::KIND_CLEAR;
         hfil_pkg::CMD_INSERT: kind = hfil_pkg::KIND_INSERT;
         hfil_pkg::CMD_LOOKUP: kind = hfil_pkg::KIND_LOOKUP;
         default:              kind = hfil_pkg::KIND_IDLE;
      endcase
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      if (req_valid && req_ready) begin
         job_valid_in    = 1'b1;
         job_in.kind     = kind;
         job_in.key      = req.key;
         job_in.key_zero = (req.key == '0);
         job_in.home     = hfil_pkg::home_slot(req.key);
      end else if (job_ready) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
   end

endmodule

/* rtl/core/hfil_queue.sv */
// short job queue between the classifying front and the probe engine
module hfil_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  hfil_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output hfil_pkg::job_type out_job
);

   hfil_pkg::job_type                entries_ff [hfil_pkg::QUEUE_DEPTH];
   logic [hfil_pkg::QPTR_BITS-1:0]   wr_ptr_ff;
   logic [hfil_pkg::QPTR_BITS-1:0]   wr_ptr_in;
   logic [hfil_pkg::QPTR_BITS-1:0]   rd_ptr_ff;
   logic [hfil_pkg::QPTR_BITS-1:0]   rd_ptr_in;
   logic [hfil_pkg::QCNT_BITS-1:0]   count_ff;
   logic [hfil_pkg::QCNT_BITS-1:0]   count_in;
   logic                             push;
   logic                             pop;

   assign in_ready  = (count_ff != hfil_pkg::QCNT_BITS'(hfil_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == hfil_pkg::QPTR_BITS'(hfil_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == hfil_pkg::QPTR_BITS'(hfil_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

/* rtl/core/hfil_back.sv */
// probe engine: slot memory, linear probing, list state and result register
module hfil_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  hfil_pkg::job_type job,
   output logic             init_done,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hfil_pkg::rsp_type rsp
);

   typedef enum logic [1:0] {
      S_WIPE,
      S_IDLE,
      S_PROBE,
      S_SEND
   } state_type;

   // slot memory and its registered read port
   hfil_pkg::entry_type slot_mem_ff [hfil_pkg::TABLE_SLOTS];
   hfil_pkg::entry_type rd_data_ff;
   logic                               rd_en;
   logic [hfil_pkg::SLOT_BITS-1:0]     rd_addr;
   logic                               wr_en;
   logic [hfil_pkg::SLOT_BITS-1:0]     wr_addr;
   hfil_pkg::entry_type                wr_data;

   state_type                          state_ff, state_in;
   hfil_pkg::job_type                  job_ff, job_in;
   logic [hfil_pkg::SLOT_BITS-1:0]     idx_ff, idx_in;
   logic [hfil_pkg::SLOT_BITS-1:0]     probe_cnt_ff, probe_cnt_in;
   logic [hfil_pkg::SLOT_BITS-1:0]     wipe_idx_ff, wipe_idx_in;
   logic [hfil_pkg::POSITION_BITS-1:0] count_ff, count_in;
   logic                               zero_seen_ff, zero_seen_in;
   logic [hfil_pkg::POSITION_BITS-1:0] zero_pos_ff, zero_pos_in;
   logic [hfil_pkg::EPOCH_BITS-1:0]    epoch_ff, epoch_in;
   logic                               reply_after_wipe_ff, reply_after_wipe_in;
   logic                               init_done_ff, init_done_in;
   hfil_pkg::rsp_type                  res_ff, res_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   hfil_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                               done;
   hfil_pkg::rsp_type                  res;
   logic                               out_free;
   logic                               slot_live;

   assign job_ready = (state_ff == S_IDLE);
   assign init_done = init_done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // an entry counts only when written under the current generation tag
   assign slot_live = (rd_data_ff.epoch == epoch_ff);

   always_comb begin
      state_in            = state_ff;
      job_in              = job_ff;
      idx_in              = idx_ff;
      probe_cnt_in        = probe_cnt_ff;
      wipe_idx_in         = wipe_idx_ff;
      count_in            = count_ff;
      zero_seen_in        = zero_seen_ff;
      zero_pos_in         = zero_pos_ff;
      epoch_in            = epoch_ff;
      reply_after_wipe_in = reply_after_wipe_ff;
      init_done_in        = init_done_ff;
      res_in              = res_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_in              = rsp_ff;
      rd_en               = 1'b0;
      rd_addr             = idx_ff;
      wr_en               = 1'b0;
      wr_addr             = idx_ff;
      wr_data.epoch       = epoch_ff;
      wr_data.key         = job_ff.key;
      wr_data.position    = count_ff;
      done                = 1'b0;
      res                 = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_WIPE: begin
            wr_en       = 1'b1;
            wr_addr     = wipe_idx_ff;
            wr_data     = '0;
            wipe_idx_in = wipe_idx_ff + 1'b1;
            if (wipe_idx_ff == '1) begin
               init_done_in        = 1'b1;
               reply_after_wipe_in = 1'b0;
               state_in            = reply_after_wipe_ff ? S_SEND : S_IDLE;
            end
         end

         S_IDLE: begin
            if (job_valid) begin
               job_in = job;
               unique case (job.kind)
                  hfil_pkg::KIND_CLEAR: begin
                     count_in     = '0;
                     zero_seen_in = 1'b0;
                     zero_pos_in  = '0;
                     if (epoch_ff == '1) begin
                        // tag space used up: sweep the table, then reply
                        epoch_in            = hfil_pkg::EPOCH_BITS'(1);
                        res_in              = '0;
                        reply_after_wipe_in = 1'b1;
                        wipe_idx_in         = '0;
                        state_in            = S_WIPE;
                     end else begin
                        epoch_in = epoch_ff + 1'b1;
                        done     = 1'b1;
                     end
                  end
                  hfil_pkg::KIND_INSERT: begin
                     if (count_ff == hfil_pkg::COUNT_MAX) begin
                        res.position = hfil_pkg::COUNT_MAX;
                        res.status   = hfil_pkg::STATUS_SATURATED;
                        done         = 1'b1;
                     end else if (job.key_zero) begin
                        if (!zero_seen_ff) begin
                           zero_seen_in = 1'b1;
                           zero_pos_in  = count_ff;
                        end
                        res.position = count_ff;
                        count_in     = count_ff + 1'b1;
                        done         = 1'b1;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = job.home;
                        idx_in       = job.home;
                        probe_cnt_in = '0;
                        state_in     = S_PROBE;
                     end
                  end
                  hfil_pkg::KIND_LOOKUP: begin
                     if (job.key_zero) begin
                        res.position = zero_seen_ff ? zero_pos_ff : count_ff;
                        res.found    = zero_seen_ff;
                        done         = 1'b1;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = job.home;
                        idx_in       = job.home;
                        probe_cnt_in = '0;
                        state_in     = S_PROBE;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         S_PROBE: begin
            priority if (!slot_live) begin
               // empty slot ends the probe
               res.position = count_ff;
               if (job_ff.kind == hfil_pkg::KIND_INSERT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               done = 1'b1;
            end else if (rd_data_ff.key == job_ff.key) begin
               if (job_ff.kind == hfil_pkg::KIND_INSERT) begin
                  res.position = count_ff;
                  count_in     = count_ff + 1'b1;
               end else begin
                  res.position = rd_data_ff.position;
                  res.found    = 1'b1;
               end
               done = 1'b1;
            end else if (probe_cnt_ff == '1) begin
               // every slot visited: table full
               res.position = count_ff;
               if (job_ff.kind == hfil_pkg::KIND_INSERT) begin
                  res.status = hfil_pkg::STATUS_FULL;
                  count_in   = count_ff + 1'b1;
               end
               done = 1'b1;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff + 1'b1;
               idx_in       = idx_ff + 1'b1;
               probe_cnt_in = probe_cnt_ff + 1'b1;
            end
         end

         S_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = S_IDLE;
         end else begin
            res_in   = res;
            state_in = S_SEND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_WIPE;
         wipe_idx_ff         <= '0;
         count_ff            <= '0;
         zero_seen_ff        <= 1'b0;
         zero_pos_ff         <= '0;
         epoch_ff            <= hfil_pkg::EPOCH_BITS'(1);
         reply_after_wipe_ff <= 1'b0;
         init_done_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         wipe_idx_ff         <= wipe_idx_in;
         count_ff            <= count_in;
         zero_seen_ff        <= zero_seen_in;
         zero_pos_ff         <= zero_pos_in;
         epoch_ff            <= epoch_in;
         reply_after_wipe_ff <= reply_after_wipe_in;
         init_done_ff        <= init_done_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      job_ff       <= job_in;
      idx_ff       <= idx_in;
      probe_cnt_ff <= probe_cnt_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the hashed first-index lookup core
`timescale 1ns / 1ps

module tb;

   localparam int              CYCLE_LIMIT   = 10_000_000;
   localparam int              RANDOM_ITEMS  = 1250;
   localparam logic [31:0]     GOLDEN_MULT   = 32'd2654435761;
   // the fourth command code has no meaning and must answer all zero
   localparam logic [1:0]      CMD_SPARE     = 2'd3;

   typedef enum logic [1:0] {
      PROBE_HIT,
      PROBE_EMPTY,
      PROBE_EXHAUSTED
   } probe_result_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [31:0]       key;
      logic              typed;
      hfil_pkg::rsp_type want;
   } stim_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_ready;
   hfil_pkg::req_type req        = '0;
   logic              rsp_valid;
   logic              rsp_ready  = 1'b0;
   hfil_pkg::rsp_type rsp;

   logic tx_pace      = 1'b1;
   logic rx_pace      = 1'b1;
   logic random_phase = 1'b0;

   int                cycle_count    = 0;
   int                mismatch_count = 0;
   int                answers_taken  = 0;
   hfil_pkg::rsp_type pending_answers[$];
   logic [31:0]       list_keys[$];
   stim_row_type      directed_rows[25];

   // mirror of the index table
   logic [31:0]                        mirror_key[hfil_pkg::TABLE_SLOTS];
   logic [hfil_pkg::POSITION_BITS-1:0] mirror_pos[hfil_pkg::TABLE_SLOTS];
   bit                                 mirror_taken[hfil_pkg::TABLE_SLOTS];
   logic [hfil_pkg::POSITION_BITS-1:0] list_count   = '0;
   logic                               zero_in_list = 1'b0;
   logic [hfil_pkg::POSITION_BITS-1:0] zero_first   = '0;

   hashed_first_index_lookup_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int home_of(input logic [31:0] k);
      logic [63:0] prod;
      prod = {32'd0, k} * {32'd0, GOLDEN_MULT};
      return int'(prod[hfil_pkg::SLOT_BITS-1:0]);
   endfunction

   // linear probe with wrap from the home slot
   function automatic probe_result_type probe_table(input logic [31:0] k, output int slot);
      int home;
      home = home_of(k);
      slot = home;
      for (int n = 0; n < hfil_pkg::TABLE_SLOTS; n++) begin
         slot = (home + n) % hfil_pkg::TABLE_SLOTS;
         if (!mirror_taken[slot]) return PROBE_EMPTY;
         if (mirror_key[slot] == k) return PROBE_HIT;
      end
      return PROBE_EXHAUSTED;
   endfunction

   function automatic hfil_pkg::rsp_type index_answer(input hfil_pkg::req_type beat);
      hfil_pkg::rsp_type ans;
      int                slot;
      probe_result_type  pr;
      ans = '0;
      case (beat.command)
         hfil_pkg::CMD_CLEAR: begin
            mirror_taken = '{default: 1'b0};
            list_count   = '0;
            zero_in_list = 1'b0;
            zero_first   = '0;
         end
         hfil_pkg::CMD_INSERT: begin
            if (list_count == hfil_pkg::COUNT_MAX) begin
               ans.position = hfil_pkg::COUNT_MAX;
               ans.status   = hfil_pkg::STATUS_SATURATED;
            end else begin
               ans.position = list_count;
               if (beat.key == 0) begin
                  if (!zero_in_list) begin
                     zero_in_list = 1'b1;
                     zero_first   = list_count;
                  end
               end else begin
                  pr = probe_table(beat.key, slot);
                  if (pr == PROBE_EMPTY) begin
                     mirror_taken[slot] = 1'b1;
                     mirror_key[slot]   = beat.key;
                     mirror_pos[slot]   = list_count;
                  end else if (pr == PROBE_EXHAUSTED) begin
                     // key dropped but still takes its position
                     ans.status = hfil_pkg::STATUS_FULL;
                  end
               end
               list_count++;
            end
         end
         hfil_pkg::CMD_LOOKUP: begin
            ans.position = list_count;
            if (beat.key == 0) begin
               if (zero_in_list) begin
                  ans.position = zero_first;
                  ans.found    = 1'b1;
               end
            end else if (probe_table(beat.key, slot) == PROBE_HIT) begin
               ans.position = mirror_pos[slot];
               ans.found    = 1'b1;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return $urandom;
         // few distinct low bits, so homes collide and clusters form
         1: return ($urandom_range(0, 15) << hfil_pkg::SLOT_BITS) | $urandom_range(0, 7);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'h0000_0001;
            endcase
         end
         3: begin
            if (list_keys.size() > 0)
               return list_keys[$urandom_range(0, list_keys.size() - 1)];
            return $urandom;
         end
         4: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(input logic [1:0] cmd, input logic [31:0] key,
                            input logic typed, input hfil_pkg::rsp_type want);
      int                gap;
      hfil_pkg::req_type beat;
      hfil_pkg::rsp_type ans;
      beat.command = cmd;
      beat.key     = key;
      gap = tx_pace ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req       <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      ans = index_answer(beat);
      pending_answers.push_back(typed ? want : ans);
   endtask

   task automatic run_random(input int budget);
      int          sent;
      int          n_fill;
      int          n_probe;
      logic [31:0] k;
      logic [1:0]  cmd;
      sent = 0;
      // insert, clear, look up again: old generations must read as empty
      for (int i = 0; i < 70; i++) begin
         k = $urandom | 32'h1;
         send_beat(hfil_pkg::CMD_INSERT, k, 1'b0, '0);
         send_beat(hfil_pkg::CMD_CLEAR, $urandom, 1'b0, '0);
         send_beat(hfil_pkg::CMD_LOOKUP, k, 1'b0, '0);
         sent += 3;
      end
      while (sent < budget) begin
         tx_pace = ($urandom_range(0, 3) != 0);
         rx_pace = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0) begin
            send_beat(hfil_pkg::CMD_CLEAR, $urandom, 1'b0, '0);
            list_keys.delete();
            sent++;
         end
         n_fill = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 40);
         repeat (n_fill) begin
            k = pick_key();
            case ($urandom_range(0, 15))
               0: cmd = CMD_SPARE;
               1: cmd = hfil_pkg::CMD_LOOKUP;
               default: begin
                  cmd = hfil_pkg::CMD_INSERT;
                  list_keys.push_back(k);
               end
            endcase
            send_beat(cmd, k, 1'b0, '0);
            if (cmd != CMD_SPARE) sent++;
         end
         n_probe = $urandom_range(1, 40);
         repeat (n_probe) begin
            if (list_keys.size() > 0 && $urandom_range(0, 1) == 1)
               k = list_keys[$urandom_range(0, list_keys.size() - 1)];
            else
               k = pick_key();
            cmd = ($urandom_range(0, 19) == 0) ? CMD_SPARE : hfil_pkg::CMD_LOOKUP;
            send_beat(cmd, k, 1'b0, '0);
            if (cmd != CMD_SPARE) sent++;
         end
      end
   endtask

   initial begin : stimulus
      directed_rows = '{
         {hfil_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h7fff_ffff, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h7fff_ffff, 1'b1, 16'd1, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 16'd2, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'hffff_ffff, 1'b1, 16'd3, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, 16'd4, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 16'd5, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h8000_0000, 1'b1, 16'd0, 1'b1, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, 16'd2, 1'b1, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h7fff_ffff, 1'b1, 16'd1, 1'b1, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'hffff_ffff, 1'b1, 16'd3, 1'b1, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h0000_0001, 1'b1, 16'd6, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h0000_0001, 1'b0, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h0000_0401, 1'b0, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h0000_0801, 1'b0, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h0000_0801, 1'b0, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h0000_0c01, 1'b0, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {CMD_SPARE,            32'hffff_ffff, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h0000_0401, 1'b0, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_CLEAR,  32'h1234_5678, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h8000_0000, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_INSERT, 32'h5555_5555, 1'b1, 16'd0, 1'b0, hfil_pkg::STATUS_OK},
         {hfil_pkg::CMD_LOOKUP, 32'haaaa_aaaa, 1'b1, 16'd1, 1'b0, hfil_pkg::STATUS_OK}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].command, directed_rows[i].key,
                   directed_rows[i].typed, directed_rows[i].want);

      // keys 1..1024 land on distinct home slots and fill the table exactly
      tx_pace = 1'b0;
      rx_pace = 1'b0;
      send_beat(hfil_pkg::CMD_CLEAR, 32'h0, 1'b0, '0);
      for (int i = 1; i <= hfil_pkg::TABLE_SLOTS; i++)
         send_beat(hfil_pkg::CMD_INSERT, i, 1'b0, '0);
      send_beat(hfil_pkg::CMD_INSERT, 32'd1025, 1'b1,
                {16'd1024, 1'b0, hfil_pkg::STATUS_FULL});
      send_beat(hfil_pkg::CMD_LOOKUP, 32'd1025, 1'b0, '0);
      send_beat(hfil_pkg::CMD_LOOKUP, 32'd2048, 1'b0, '0);
      send_beat(hfil_pkg::CMD_LOOKUP, 32'd700, 1'b0, '0);
      send_beat(hfil_pkg::CMD_INSERT, 32'd0, 1'b0, '0);
      send_beat(hfil_pkg::CMD_INSERT, 32'd7, 1'b0, '0);
      send_beat(hfil_pkg::CMD_LOOKUP, 32'd0, 1'b0, '0);

      // run the item count up to its ceiling, mostly with cheap zero keys
      send_beat(hfil_pkg::CMD_CLEAR, 32'h0, 1'b0, '0);
      for (int i = 0; i < int'(hfil_pkg::COUNT_MAX); i++)
         send_beat(hfil_pkg::CMD_INSERT, (i % 4096 == 99) ? $urandom : 32'h0, 1'b0, '0);
      send_beat(hfil_pkg::CMD_INSERT, 32'h0, 1'b1,
                {hfil_pkg::COUNT_MAX, 1'b0, hfil_pkg::STATUS_SATURATED});
      send_beat(hfil_pkg::CMD_INSERT, 32'h0000_1234, 1'b1,
                {hfil_pkg::COUNT_MAX, 1'b0, hfil_pkg::STATUS_SATURATED});
      send_beat(hfil_pkg::CMD_LOOKUP, 32'h0000_1234, 1'b0, '0);
      send_beat(hfil_pkg::CMD_LOOKUP, 32'h0, 1'b1, {16'd0, 1'b1, hfil_pkg::STATUS_OK});

      random_phase = 1'b1;
      tx_pace      = 1'b1;
      rx_pace      = 1'b1;
      run_random(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : receiver
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = rx_pace ? $urandom_range(0, 14) : 0;
         // long hold-off so the core backs up and drops req_ready
         if (random_phase && answers_taken % 400 == 200) gap = 300;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         answers_taken++;
      end
   end

   always @(posedge clock) begin : check_answers
      hfil_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response beat: position %0d found %0b status %0d",
                        rsp.position, rsp.found, rsp.status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp.position !== want.position || rsp.found !== want.found ||
                rsp.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch at cycle %0d: expected position %0d found %0b status %0d",
                           cycle_count, want.position, want.found, want.status);
                  $display("   got position %0d found %0b status %0d",
                           rsp.position, rsp.found, rsp.status);
               end
            end
         end
      end
   end

endmodule
